@@ design/ckmer_pkg.sv @@
`default_nettype none

package ckmer_pkg;

    // Widths fixed by the interface
    localparam int CKMER_CHAR_W   = 8;
    localparam int CKMER_CFG_W    = 6;
    localparam int CKMER_OUT_W    = 64;

    // Window size limits and reset value
    localparam int CKMER_MAX_KMER = 32;
    localparam int CKMER_MIN_KMER = 4;
    localparam logic [CKMER_CFG_W-1:0] CKMER_KMER_RESET = 6'd31;

    // 2-bit base codes
    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    typedef struct packed {
        logic                   ok;
        logic [1:0]             code;
    } t_base;

    typedef struct packed {
        logic [CKMER_OUT_W-1:0] kmer;
        logic                   valid;
        logic                   rev;
    } t_kmer_result;

    function automatic t_base base_decode(input logic [CKMER_CHAR_W-1:0] ch);
        t_base b;
        b.ok   = 1'b1;
        b.code = BASE_A;
        unique case (ch)
            8'h41, 8'h61: b.code = BASE_A;
            8'h43, 8'h63: b.code = BASE_C;
            8'h47, 8'h67: b.code = BASE_G;
            8'h54, 8'h74: b.code = BASE_T;
            default:      b.ok   = 1'b0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ design/canonical_kmer_encoder.sv @@
`default_nettype none

// Channel   Direction  Handshake                     Payload
// input     in         i_in_valid / o_in_stall       i_base_char, i_read_start
// result    out        o_out_valid / i_out_stall     o_canonical_kmer, o_kmer_valid,
//                                                    o_from_reverse
// config    in         i_cfg_valid / o_cfg_ready     i_cfg_kmer_size
//
// One transfer in each cycle on both sides while neither side stalls; a character
// is taken into the input register and its result then into the result register.
// The window update and the 64-bit strand compare sit between those registers.
// Reset (synchronous, active low) empties both stages, clears the windows and
// loads a window size of 31. A stalled result register holds the input register,
// which then raises o_in_stall; the config port is always ready.
module canonical_kmer_encoder
    import ckmer_pkg::*;
#(
    parameter int MAX_KMER = CKMER_MAX_KMER
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // input channel
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [CKMER_CHAR_W-1:0] i_base_char,
    input  wire logic                    i_read_start,
    // result channel
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic      [CKMER_OUT_W-1:0]  o_canonical_kmer,
    output logic                         o_kmer_valid,
    output logic                         o_from_reverse,
    // configuration channel
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CKMER_CFG_W-1:0]  i_cfg_kmer_size
);

    localparam int WIN_W = 2 * MAX_KMER;
    localparam int RUN_W = $clog2(MAX_KMER + 1);

    // Input register
    logic                    r_in_vld;
    logic [CKMER_CHAR_W-1:0] r_char;
    logic                    r_start;
    // Window state
    logic [WIN_W-1:0]        r_fwd;
    logic [WIN_W-1:0]        r_rev;
    logic [RUN_W-1:0]        r_run;
    logic [CKMER_CFG_W-1:0]  r_kmer_size;
    // Result register
    logic                    r_out_vld;
    t_kmer_result            r_result;

    logic [WIN_W-1:0]        n_fwd;
    logic [WIN_W-1:0]        n_rev;
    logic [RUN_W-1:0]        n_run;
    t_kmer_result            n_result;

    logic out_free;
    logic advance;
    logic in_xfer;
    logic cfg_xfer;

    // Result register can load when empty or being drained this cycle
    assign out_free   = !r_out_vld || !i_out_stall;
    assign advance    = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_xfer   = i_cfg_valid && o_cfg_ready;

    ckmer_step #(
        .MAX_KMER (MAX_KMER)
    ) u_step (
        .i_kmer_size  (r_kmer_size),
        .i_base_char  (r_char),
        .i_read_start (r_start),
        .i_fwd        (r_fwd),
        .i_rev        (r_rev),
        .i_run        (r_run),
        .o_fwd        (n_fwd),
        .o_rev        (n_rev),
        .o_run        (n_run),
        .o_result     (n_result)
    );

    // Control: stage valids, window state, window size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_fwd       <= '0;
            r_rev       <= '0;
            r_run       <= '0;
            r_kmer_size <= CKMER_KMER_RESET;
        end else begin
            // hold input stage while stalled, refill on each transfer
            if (in_xfer) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
            // a new window size restarts the window; otherwise slide on advance
            if (cfg_xfer) begin
                r_kmer_size <= i_cfg_kmer_size;
                r_fwd       <= '0;
                r_rev       <= '0;
                r_run       <= '0;
            end else if (advance) begin
                r_fwd <= n_fwd;
                r_rev <= n_rev;
                r_run <= n_run;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_char  <= i_base_char;
            r_start <= i_read_start;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_canonical_kmer = r_result.kmer;
    assign o_kmer_valid     = r_result.valid;
    assign o_from_reverse   = r_result.rev;

endmodule

`default_nettype wire

@@ design/ckmer_step.sv @@
`default_nettype none

// Next window state and result for one character.
module ckmer_step
    import ckmer_pkg::*;
#(
    parameter int MAX_KMER = CKMER_MAX_KMER,
    localparam int WIN_W   = 2 * MAX_KMER,
    localparam int RUN_W   = $clog2(MAX_KMER + 1)
) (
    input  wire logic [CKMER_CFG_W-1:0]  i_kmer_size,
    input  wire logic [CKMER_CHAR_W-1:0] i_base_char,
    input  wire logic                    i_read_start,
    input  wire logic [WIN_W-1:0]        i_fwd,
    input  wire logic [WIN_W-1:0]        i_rev,
    input  wire logic [RUN_W-1:0]        i_run,
    output logic      [WIN_W-1:0]        o_fwd,
    output logic      [WIN_W-1:0]        o_rev,
    output logic      [RUN_W-1:0]        o_run,
    output t_kmer_result                 o_result
);

    logic [CKMER_CFG_W-1:0] k_eff;
    t_base                  base;
    logic [WIN_W-1:0]       mask;
    logic [WIN_W-1:0]       ins;
    logic [WIN_W-1:0]       fwd_base;
    logic [WIN_W-1:0]       rev_base;
    logic [RUN_W-1:0]       run_base;
    logic [WIN_W-1:0]       fwd_n;
    logic [WIN_W-1:0]       rev_n;
    logic [RUN_W-1:0]       run_n;

    always_comb begin
        priority if (i_kmer_size < CKMER_CFG_W'(CKMER_MIN_KMER)) begin
            k_eff = CKMER_CFG_W'(CKMER_MIN_KMER);
        end else if (i_kmer_size > CKMER_CFG_W'(MAX_KMER)) begin
            k_eff = CKMER_CFG_W'(MAX_KMER);
        end else begin
            k_eff = i_kmer_size;
        end
    end

    assign base = base_decode(i_base_char);

    // Per-base mask and complement insert at base slot k-1
    always_comb begin
        for (int j = 0; j < MAX_KMER; j++) begin
            mask[2*j +: 2] = (CKMER_CFG_W'(j) < k_eff) ? 2'b11 : 2'b00;
            ins[2*j +: 2]  = (CKMER_CFG_W'(j + 1) == k_eff) ? ~base.code : 2'b00;
        end
    end

    assign fwd_base = i_read_start ? '0 : i_fwd;
    assign rev_base = i_read_start ? '0 : i_rev;
    assign run_base = i_read_start ? '0 : i_run;

    assign fwd_n = ({fwd_base[WIN_W-3:0], base.code}) & mask;
    assign rev_n = ((rev_base >> 2) | ins) & mask;
    assign run_n = (run_base < RUN_W'(k_eff)) ? run_base + RUN_W'(1) : run_base;

    always_comb begin
        o_result = '0;
        if (!base.ok) begin
            o_fwd = '0;
            o_rev = '0;
            o_run = '0;
        end else begin
            o_fwd = fwd_n;
            o_rev = rev_n;
            o_run = run_n;
            if (run_n >= RUN_W'(k_eff)) begin
                o_result.valid = 1'b1;
                if (rev_n < fwd_n) begin
                    o_result.kmer = CKMER_OUT_W'(rev_n);
                    o_result.rev  = 1'b1;
                end else begin
                    o_result.kmer = CKMER_OUT_W'(fwd_n);
                end
            end
        end
    end

endmodule

`default_nettype wire
